[sv/bitfield_pixel_unpacker_defines.svh]
// Assertion macros shared by the pixel unpacker RTL.
// Bodies refer to clk and rst_n of the module that uses them.
`ifndef BITFIELD_PIXEL_UNPACKER_DEFINES_SVH
`define BITFIELD_PIXEL_UNPACKER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BPU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BPU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/bpu_pkg.sv]
// Types and constants of the bitfield pixel unpacker.
// No dependencies; used by every module.
package bpu_pkg;

    // Pixel format codes
    typedef enum logic [1:0] {
        FMT_GREY = 2'd0,
        FMT_16   = 2'd1,
        FMT_24   = 2'd2,
        FMT_32   = 2'd3
    } fmt_t;

    // Register indexes (word address)
    localparam logic [2:0] REG_PIXEL_FORMAT     = 3'd0;
    localparam logic [2:0] REG_BITFIELDS_ENABLE = 3'd1;
    localparam logic [2:0] REG_RED_MASK         = 3'd2;
    localparam logic [2:0] REG_GREEN_MASK       = 3'd3;
    localparam logic [2:0] REG_BLUE_MASK        = 3'd4;
    localparam logic [2:0] REG_ALPHA_MASK       = 3'd5;

    localparam int ADDR_W = 5;

    // Default masks, 5-5-5 for 16-bit
    localparam logic [31:0] MASK16_RED   = 32'h0000_7C00;
    localparam logic [31:0] MASK16_GREEN = 32'h0000_03E0;
    localparam logic [31:0] MASK16_BLUE  = 32'h0000_001F;
    localparam logic [31:0] PIX16_KEEP   = 32'h0000_FFFF;

    // Default masks, 8-8-8-8 for 32-bit
    localparam logic [31:0] MASK32_RED   = 32'h00FF_0000;
    localparam logic [31:0] MASK32_GREEN = 32'h0000_FF00;
    localparam logic [31:0] MASK32_BLUE  = 32'h0000_00FF;
    localparam logic [31:0] MASK32_ALPHA = 32'hFF00_0000;
    localparam logic [31:0] MASK_NONE    = 32'h0000_0000;
    localparam logic [31:0] PIX_KEEP_ALL = 32'hFFFF_FFFF;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    localparam logic [2:0] CNT_ONE   = 3'd1;
    localparam logic [2:0] CNT_THREE = 3'd3;
    localparam logic [2:0] CNT_FOUR  = 3'd4;

    // One channel: bits to keep and left shift that brings the mask top to bit 31
    typedef struct packed {
        logic [31:0] and_mask;
        logic [4:0]  shift;
    } chan_cfg_t;

    // Settings derived from the registers, ready for the datapath
    typedef struct packed {
        chan_cfg_t  red;
        chan_cfg_t  green;
        chan_cfg_t  blue;
        chan_cfg_t  alpha;
        logic       alpha_fill;
        logic [2:0] count;
    } cfg_t;

endpackage

[sv/bpu_if.sv]
// Valid/ready channel interfaces of the pixel unpacker.
// Depends on no other file.
interface bpu_pix_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_word;

    modport source (output valid, output pixel_word, input ready);
    modport sink   (input valid, input pixel_word, output ready);
endinterface

interface bpu_rgba_if;
    logic       valid;
    logic       ready;
    logic [7:0] chan_red;
    logic [7:0] chan_green;
    logic [7:0] chan_blue;
    logic [7:0] chan_alpha;
    logic [2:0] channel_count;

    modport source (output valid, output chan_red, output chan_green, output chan_blue,
                    output chan_alpha, output channel_count, input ready);
    modport sink   (input valid, input chan_red, input chan_green, input chan_blue,
                    input chan_alpha, input channel_count, output ready);
endinterface

[sv/bpu_regs.sv]
// APB register file of the pixel unpacker and the derived per-channel settings.
// Depends on bpu_pkg.
module bpu_regs
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bpu_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output bpu_pkg::cfg_t               cfg
);

    // Count leading zeros in five halving steps
    function automatic logic [4:0] lead_zeros(input logic [31:0] v);
        logic [31:0] x;
        logic [4:0]  n;
        begin
            x = v;
            n = 5'd0;
            if (x[31:16] == 16'h0)
            begin
                n[4] = 1'b1;
                x = {x[15:0], 16'h0};
            end
            if (x[31:24] == 8'h0)
            begin
                n[3] = 1'b1;
                x = {x[23:0], 8'h0};
            end
            if (x[31:28] == 4'h0)
            begin
                n[2] = 1'b1;
                x = {x[27:0], 4'h0};
            end
            if (x[31:30] == 2'h0)
            begin
                n[1] = 1'b1;
                x = {x[29:0], 2'h0};
            end
            if (!x[31])
            begin
                n[0] = 1'b1;
            end
            return n;
        end
    endfunction

    bpu_pkg::fmt_t format_reg;
    logic          bf_enable_reg;
    logic [31:0]   red_mask_reg;
    logic [31:0]   green_mask_reg;
    logic [31:0]   blue_mask_reg;
    logic [31:0]   alpha_mask_reg;
    bpu_pkg::cfg_t cfg_reg;
    bpu_pkg::cfg_t cfg_next;

    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    // Write the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg     <= bpu_pkg::FMT_32;
            bf_enable_reg  <= 1'b0;
            red_mask_reg   <= bpu_pkg::MASK32_RED;
            green_mask_reg <= bpu_pkg::MASK32_GREEN;
            blue_mask_reg  <= bpu_pkg::MASK32_BLUE;
            alpha_mask_reg <= bpu_pkg::MASK_NONE;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                bpu_pkg::REG_PIXEL_FORMAT:     format_reg     <= bpu_pkg::fmt_t'(pwdata[1:0]);
                bpu_pkg::REG_BITFIELDS_ENABLE: bf_enable_reg  <= pwdata[0];
                bpu_pkg::REG_RED_MASK:         red_mask_reg   <= pwdata;
                bpu_pkg::REG_GREEN_MASK:       green_mask_reg <= pwdata;
                bpu_pkg::REG_BLUE_MASK:        blue_mask_reg  <= pwdata;
                bpu_pkg::REG_ALPHA_MASK:       alpha_mask_reg <= pwdata;
                default: ;
            endcase
        end
    end

    // Read back the raw register values
    always_comb
    begin
        case (reg_idx)
            bpu_pkg::REG_PIXEL_FORMAT:     prdata = {30'h0, format_reg};
            bpu_pkg::REG_BITFIELDS_ENABLE: prdata = {31'h0, bf_enable_reg};
            bpu_pkg::REG_RED_MASK:         prdata = red_mask_reg;
            bpu_pkg::REG_GREEN_MASK:       prdata = green_mask_reg;
            bpu_pkg::REG_BLUE_MASK:        prdata = blue_mask_reg;
            bpu_pkg::REG_ALPHA_MASK:       prdata = alpha_mask_reg;
            default:                       prdata = 32'h0;
        endcase
    end

    // Map every format onto four masked channels; grey and BGR are fixed masks
    always_comb
    begin
        logic [31:0] m_r;
        logic [31:0] m_g;
        logic [31:0] m_b;
        logic [31:0] m_a;
        logic [31:0] keep;
        m_r  = bpu_pkg::MASK_NONE;
        m_g  = bpu_pkg::MASK_NONE;
        m_b  = bpu_pkg::MASK_NONE;
        m_a  = bpu_pkg::MASK_NONE;
        keep = bpu_pkg::PIX_KEEP_ALL;
        cfg_next.alpha_fill = 1'b0;
        cfg_next.count      = bpu_pkg::CNT_THREE;
        case (format_reg)
            bpu_pkg::FMT_GREY:
            begin
                m_r = bpu_pkg::MASK32_BLUE;
                cfg_next.count = bpu_pkg::CNT_ONE;
            end
            bpu_pkg::FMT_16:
            begin
                keep = bpu_pkg::PIX16_KEEP;
                m_r  = bf_enable_reg ? red_mask_reg   : bpu_pkg::MASK16_RED;
                m_g  = bf_enable_reg ? green_mask_reg : bpu_pkg::MASK16_GREEN;
                m_b  = bf_enable_reg ? blue_mask_reg  : bpu_pkg::MASK16_BLUE;
                m_a  = bf_enable_reg ? alpha_mask_reg : bpu_pkg::MASK_NONE;
                cfg_next.count = (m_a != bpu_pkg::MASK_NONE) ? bpu_pkg::CNT_FOUR
                                                             : bpu_pkg::CNT_THREE;
            end
            bpu_pkg::FMT_24:
            begin
                m_r = bpu_pkg::MASK32_RED;
                m_g = bpu_pkg::MASK32_GREEN;
                m_b = bpu_pkg::MASK32_BLUE;
            end
            bpu_pkg::FMT_32:
            begin
                m_r = bf_enable_reg ? red_mask_reg   : bpu_pkg::MASK32_RED;
                m_g = bf_enable_reg ? green_mask_reg : bpu_pkg::MASK32_GREEN;
                m_b = bf_enable_reg ? blue_mask_reg  : bpu_pkg::MASK32_BLUE;
                m_a = bf_enable_reg ? alpha_mask_reg : bpu_pkg::MASK32_ALPHA;
                cfg_next.alpha_fill = (m_a == bpu_pkg::MASK_NONE);
                cfg_next.count      = bpu_pkg::CNT_FOUR;
            end
            default: ;
        endcase
        // The shift follows the full mask; the 16-bit pixel limit applies to the AND only
        cfg_next.red.and_mask   = m_r & keep;
        cfg_next.red.shift      = lead_zeros(m_r);
        cfg_next.green.and_mask = m_g & keep;
        cfg_next.green.shift    = lead_zeros(m_g);
        cfg_next.blue.and_mask  = m_b & keep;
        cfg_next.blue.shift     = lead_zeros(m_b);
        cfg_next.alpha.and_mask = m_a & keep;
        cfg_next.alpha.shift    = lead_zeros(m_a);
    end

    // Hold the derived settings in a register ahead of the datapath
    always_ff @(posedge clk)
    begin
        cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

[sv/bpu_chan.sv]
// One channel extractor: mask the pixel, shift by the precomputed amount, take the top byte.
// Depends on bpu_pkg.
module bpu_chan
(
    input  logic [31:0]        pixel_word,
    input  bpu_pkg::chan_cfg_t cfg,
    output logic [7:0]         chan_byte
);

    logic [31:0] shifted;

    // Align the mask top bit with bit 31; a zero mask leaves nothing to shift
    assign shifted   = (pixel_word & cfg.and_mask) << cfg.shift;
    assign chan_byte = shifted[31:24];

endmodule

[sv/bpu_core.sv]
// Two-register datapath: input register, four channel extractors, result register.
// Depends on bpu_pkg, bpu_if, bpu_chan and the assertion macro header.
`include "bitfield_pixel_unpacker_defines.svh"

module bpu_core
(
    input  logic          clk,
    input  logic          rst_n,
    input  bpu_pkg::cfg_t cfg,
    bpu_pix_if.sink       pixel,
    bpu_rgba_if.source    result
);

    logic        in_valid_reg;
    logic [31:0] in_pix_reg;
    logic        out_valid_reg;
    logic [7:0]  red_reg;
    logic [7:0]  green_reg;
    logic [7:0]  blue_reg;
    logic [7:0]  alpha_reg;
    logic [2:0]  count_reg;

    logic       out_advance;
    logic       in_advance;
    logic [7:0] red_next;
    logic [7:0] green_next;
    logic [7:0] blue_next;
    logic [7:0] alpha_raw;
    logic [7:0] alpha_next;

    // Advance a stage when the one after it is free or draining
    assign out_advance = !out_valid_reg || result.ready;
    assign in_advance  = !in_valid_reg || out_advance;
    assign pixel.ready = in_advance;

    // Capture the request into the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_advance)
        begin
            in_valid_reg <= pixel.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_advance)
        begin
            in_pix_reg <= pixel.pixel_word;
        end
    end

    bpu_chan u_red   (.pixel_word(in_pix_reg), .cfg(cfg.red),   .chan_byte(red_next));
    bpu_chan u_green (.pixel_word(in_pix_reg), .cfg(cfg.green), .chan_byte(green_next));
    bpu_chan u_blue  (.pixel_word(in_pix_reg), .cfg(cfg.blue),  .chan_byte(blue_next));
    bpu_chan u_alpha (.pixel_word(in_pix_reg), .cfg(cfg.alpha), .chan_byte(alpha_raw));

    // Opaque alpha for 32-bit pixels without an alpha mask
    assign alpha_next = cfg.alpha_fill ? bpu_pkg::ALPHA_OPAQUE : alpha_raw;

    // Load the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_advance)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            alpha_reg <= alpha_next;
            count_reg <= cfg.count;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.chan_red      = red_reg;
    assign result.chan_green    = green_reg;
    assign result.chan_blue     = blue_reg;
    assign result.chan_alpha    = alpha_reg;
    assign result.channel_count = count_reg;

    `BPU_ASSERT_NOW(a_no_overwrite, in_valid_reg && !out_advance, !pixel.ready, "input register overwritten while stalled")
    `BPU_ASSERT_NOW(a_count_legal, out_valid_reg, (count_reg == bpu_pkg::CNT_ONE) || (count_reg == bpu_pkg::CNT_THREE) || (count_reg == bpu_pkg::CNT_FOUR), "illegal channel count")
    `BPU_ASSERT_NOW(a_grey_zero, out_valid_reg && (count_reg == bpu_pkg::CNT_ONE), (green_reg == 8'h00) && (blue_reg == 8'h00) && (alpha_reg == 8'h00), "grey result has nonzero color")
    `BPU_ASSERT_NEXT(a_alpha_fill, in_valid_reg && out_advance && cfg.alpha_fill, out_valid_reg && (alpha_reg == bpu_pkg::ALPHA_OPAQUE), "alpha not filled opaque")

endmodule

[sv/bitfield_pixel_unpacker.sv]
// Top level of the bitfield pixel unpacker: register file plus datapath.
// Depends on bpu_pkg, bpu_if, bpu_regs and bpu_core.
//
// Usage:
//   pixel  : valid/ready request channel carrying one 32-bit pixel word
//            (byte 0 in bits 7..0).
//   result : valid/ready channel carrying red, green, blue, alpha bytes and
//            the number of meaningful channels (1, 3 or 4).
//   APB    : six 32-bit registers at byte addresses 0x00..0x14; pready is
//            tied high, writes land on the access cycle.
//   Path: a pixel passes the input register, then the result register.
//   Throughput: one pixel per cycle unless stalled; both registers advance
//            together, so the channel shift logic between them sets the pace.
//   Mask shifts are derived into a register on the edge after a write, in
//            time for a pixel accepted on that edge; no idle cycle is needed.
//   Reset: both pipeline stages empty, registers at their reset values
//            (32-bit format, default masks).
//   Stall: while result.ready is low a valid result holds; one more pixel
//            enters an empty input register, then pixel.ready drops.
module bitfield_pixel_unpacker
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bpu_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    bpu_pix_if.sink                     pixel,
    bpu_rgba_if.source                  result
);

    bpu_pkg::cfg_t cfg;

    // Hold configuration and derived channel settings
    bpu_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Advance pixels through the datapath
    bpu_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .pixel  (pixel),
        .result (result)
    );

endmodule
